// ===== hdl/fle_pkg.sv =====
// Shared types, sizes and the mantissa log table for the frame log energy block.
`default_nettype none
package fle_pkg;

	localparam int ACC_BITS       = 48;
	localparam int LOG_TABLE_BITS = 6;
	localparam int FRAC_BITS      = 10;

	localparam int SAMPLE_W  = 16;
	localparam int SQ_W      = 31;
	localparam int OUT_W     = 16;
	localparam int TAB_SIZE  = 1 << LOG_TABLE_BITS;
	localparam int GRP_W     = 8;
	localparam int NUM_GRP   = (ACC_BITS + GRP_W - 1) / GRP_W;
	localparam int ACC_PAD   = NUM_GRP * GRP_W;
	localparam int GPOS_W    = $clog2(GRP_W);
	localparam int P_W       = $clog2(ACC_PAD);
	localparam int ENTRY_W   = 16;
	localparam int L2_W      = P_W + ENTRY_W;
	localparam int LN2_W     = 30;
	localparam int PROD_W    = L2_W + LN2_W;
	localparam int ROUND_SH  = 46 - FRAC_BITS;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	localparam logic [LN2_W-1:0] LN2_Q30   = LN2_W'(744261118);
	localparam logic [63:0]      ONE_Q30   = 64'd1 << 30;
	localparam logic [OUT_W-1:0] OUT_MAX   = '1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       frame_end;
	} in_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] log_energy;
		logic             zero_energy;
		logic             saturated;
	} out_item_t;

	// one finished frame on its way from accumulator to log pipeline
	typedef struct packed {
		logic [ACC_BITS-1:0] energy;
		logic                clipped;
	} frame_t;

	typedef logic [ENTRY_W-1:0] log_tab_t [TAB_SIZE];

	// log2(1 + k / TAB_SIZE) in Q16, square-and-compare on a Q30 mantissa
	function automatic log_tab_t build_log_tab();
		log_tab_t          t;
		logic [63:0]       x;
		logic [ENTRY_W-1:0] r;
		for (int k = 0; k < TAB_SIZE; k++) begin
			x = ONE_Q30 + (64'(k) << (30 - LOG_TABLE_BITS));
			r = '0;
			for (int i = 0; i < ENTRY_W; i++) begin
				x = (x * x) >> 30;
				r = {r[ENTRY_W-2:0], 1'b0};
				if (x >= (ONE_Q30 << 1)) begin
					x = x >> 1;
					r[0] = 1'b1;
				end
			end
			t[k] = r;
		end
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();

endpackage
`default_nettype wire

// ===== hdl/fle_if.sv =====
// Valid/ready stream interfaces for samples and log energy results.
`default_nettype none
interface fle_in_if;
	import fle_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface fle_out_if;
	import fle_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/frame_log_energy_top.sv =====
// Top level of the frame log energy block.
//
//   channel  dir  payload                                    beat
//   audio    in   sample (s16), frame_end                    one sample
//   energy   out  log_energy (u16, 10 frac), zero_energy,    one per frame
//                 saturated
//
// One sample beat is taken per cycle unless the front stalls. A frame result
// passes from the square-accumulate stage through the frame queue and on
// through the five log stages (byte leading-one, position/index, table,
// ln 2 multiply, round). A four-entry frame queue separates front and back;
// the front stalls only when a frame end meets a full queue. Reset clears the
// accumulator and queue.
`default_nettype none
module frame_log_energy_top (
	input  wire logic clk,
	input  wire logic arst_n,
	fle_in_if.sink    audio,
	fle_out_if.source energy
);
	import fle_pkg::*;

	frame_t push_data;
	logic   push_valid;
	logic   push_ready;
	frame_t pop_data;
	logic   pop_valid;
	logic   pop_ready;

	fle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.audio      (audio),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	fle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	fle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.energy    (energy)
	);

endmodule
`default_nettype wire

// ===== hdl/fle_front.sv =====
// Front end: square each sample and accumulate it with saturation per frame.
`default_nettype none
module fle_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	fle_in_if.sink               audio,
	output fle_pkg::frame_t      push_data,
	output logic                 push_valid,
	input  wire logic            push_ready
);
	import fle_pkg::*;

	logic [SQ_W-1:0]     sq_s1;
	logic                end_s1;
	logic                v_s1;
	logic [ACC_BITS-1:0] energy_q;
	logic                clipped_q;

	logic                adv_s1;
	logic [ACC_BITS:0]   sum;
	logic [ACC_BITS-1:0] energy_nxt;
	logic                clipped_nxt;
	logic signed [2*SAMPLE_W-1:0] prod;

	assign prod = audio.data.sample * audio.data.sample;

	// a frame end may only leave this stage when the queue has room
	assign adv_s1      = !end_s1 || push_ready;
	assign audio.ready = !v_s1 || adv_s1;

	assign sum         = {1'b0, energy_q} + (ACC_BITS + 1)'(sq_s1);
	assign energy_nxt  = sum[ACC_BITS] ? '1 : sum[ACC_BITS-1:0];
	assign clipped_nxt = clipped_q || sum[ACC_BITS];

	assign push_valid        = v_s1 && end_s1;
	assign push_data.energy  = energy_nxt;
	assign push_data.clipped = clipped_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (audio.ready) begin
			v_s1 <= audio.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (audio.valid && audio.ready) begin
			sq_s1  <= SQ_W'(prod);
			end_s1 <= audio.data.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q  <= '0;
			clipped_q <= 1'b0;
		end else if (v_s1 && adv_s1) begin
			if (end_s1) begin
				energy_q  <= '0;
				clipped_q <= 1'b0;
			end else begin
				energy_q  <= energy_nxt;
				clipped_q <= clipped_nxt;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/fle_queue.sv =====
// Short frame queue between the accumulator and the log pipeline.
`default_nettype none
module fle_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  fle_pkg::frame_t      push_data,
	input  wire logic            push_valid,
	output logic                 push_ready,
	output fle_pkg::frame_t      pop_data,
	output logic                 pop_valid,
	input  wire logic            pop_ready
);
	import fle_pkg::*;

	frame_t            mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != (QPTR_W + 1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/fle_back.sv =====
// Back end: leading-one search, table log2, ln 2 scaling and rounding.
`default_nettype none
module fle_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  fle_pkg::frame_t      pop_data,
	input  wire logic            pop_valid,
	output logic                 pop_ready,
	fle_out_if.source            energy
);
	import fle_pkg::*;

	logic                         adv;

	// stage 1: per-byte leading one
	logic                         v_s1;
	logic [ACC_PAD-1:0]           e_s1;
	logic [NUM_GRP-1:0]           nz_s1;
	logic [GPOS_W-1:0]            gpos_s1 [NUM_GRP];
	logic                         clip_s1;
	logic [ACC_PAD-1:0]           e_pad;
	logic [NUM_GRP-1:0]           nz_c;
	logic [GPOS_W-1:0]            gpos_c [NUM_GRP];

	// stage 2: leading-one position and mantissa index
	logic                         v_s2;
	logic [P_W-1:0]               p_s2;
	logic [LOG_TABLE_BITS-1:0]    idx_s2;
	logic                         zero_s2;
	logic                         clip_s2;
	logic [P_W-1:0]               p_c;
	logic [ACC_PAD+LOG_TABLE_BITS-1:0] ext;

	// stage 3: log2 in Q16
	logic                         v_s3;
	logic [L2_W-1:0]              l2_s3;
	logic                         zero_s3;
	logic                         clip_s3;

	// stage 4: scaled by ln 2
	logic                         v_s4;
	logic [PROD_W-1:0]            prod_s4;
	logic                         zero_s4;
	logic                         clip_s4;

	// stage 5: result register
	logic                         v_s5;
	out_item_t                    res_s5;
	logic [PROD_W:0]              rsum;
	logic [31:0]                  res32;

	assign adv          = !v_s5 || energy.ready;
	assign pop_ready    = adv;
	assign energy.valid = v_s5;
	assign energy.data  = res_s5;

	assign e_pad = ACC_PAD'(pop_data.energy);

	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			nz_c[g]   = |e_pad[g*GRP_W +: GRP_W];
			gpos_c[g] = '0;
			for (int b = 0; b < GRP_W; b++) begin
				if (e_pad[g*GRP_W + b]) begin
					gpos_c[g] = GPOS_W'(b);
				end
			end
		end
	end

	always_comb begin
		p_c = '0;
		for (int g = 0; g < NUM_GRP; g++) begin
			if (nz_s1[g]) begin
				p_c = P_W'(g * GRP_W) + P_W'(gpos_s1[g]);
			end
		end
	end

	// bits just below the leading one, zero filled under bit 0
	assign ext = {e_s1, {LOG_TABLE_BITS{1'b0}}};

	assign rsum  = {1'b0, prod_s4} + ((PROD_W + 1)'(1) << (ROUND_SH - 1));
	assign res32 = 32'(rsum >> ROUND_SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1    <= e_pad;
			nz_s1   <= nz_c;
			gpos_s1 <= gpos_c;
			clip_s1 <= pop_data.clipped;

			p_s2    <= p_c;
			idx_s2  <= ext[p_c +: LOG_TABLE_BITS];
			zero_s2 <= !(|nz_s1);
			clip_s2 <= clip_s1;

			l2_s3   <= {p_s2, LOG_TAB[idx_s2]};
			zero_s3 <= zero_s2;
			clip_s3 <= clip_s2;

			prod_s4 <= PROD_W'(l2_s3) * PROD_W'(LN2_Q30);
			zero_s4 <= zero_s3;
			clip_s4 <= clip_s3;

			if (zero_s4) begin
				res_s5.log_energy <= '0;
			end else if (res32 > 32'(OUT_MAX)) begin
				res_s5.log_energy <= OUT_MAX;
			end else begin
				res_s5.log_energy <= OUT_W'(res32);
			end
			res_s5.zero_energy <= zero_s4;
			res_s5.saturated   <= clip_s4;
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/frame_log_energy_top_tb.sv =====
// Self-checking testbench for frame_log_energy_top: random and directed frames, predicted logs.
`timescale 1ns / 100ps
module frame_log_energy_top_tb;
	import fle_pkg::*;

	localparam logic [ACC_BITS-1:0] ENERGY_FULL = '1;
	localparam logic [63:0]         LN2_FIX     = 64'd744261118;

	typedef enum int {MIX_FULL, MIX_QUIET, MIX_SILENT, MIX_LOUD} mix_t;

	logic clk;
	logic arst_n;

	fle_in_if  audio_ch ();
	fle_out_if energy_ch ();

	frame_log_energy_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.audio  (audio_ch),
		.energy (energy_ch)
	);

	in_item_t  sample_backlog [$];
	out_item_t expected_logs [$];

	logic [ACC_BITS-1:0] energy_acc;
	bit                  clip_seen;
	bit                  beat_taken;
	int                  send_idle_pct;
	int                  recv_stall_pct;
	int                  err_count;
	int                  beats_in;
	int                  frames_checked;
	int                  silent_frames;
	int                  clipped_frames;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// log2(1 + k / 2^LOG_TABLE_BITS) in Q16 by repeated squaring of a Q30 mantissa
	function automatic logic [15:0] frac_log2(logic [LOG_TABLE_BITS-1:0] k);
		logic [63:0] x;
		logic [15:0] r;
		x = (64'd1 << 30) + (64'(k) << (30 - LOG_TABLE_BITS));
		r = '0;
		for (int i = 0; i < 16; i++) begin
			x = (x * x) >> 30;
			r = r << 1;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				r[0] = 1'b1;
			end
		end
		return r;
	endfunction

	// natural log of a nonzero energy, FRAC_BITS fraction bits, rounded half up
	function automatic logic [OUT_W-1:0] ln_energy_q(logic [ACC_BITS-1:0] e);
		int                        msb;
		logic [LOG_TABLE_BITS-1:0] idx;
		logic [63:0]               l2;
		logic [63:0]               prod;
		logic [63:0]               rounded;
		msb = 0;
		for (int b = 0; b < ACC_BITS; b++)
			if (e[b])
				msb = b;
		if (msb >= LOG_TABLE_BITS)
			idx = LOG_TABLE_BITS'(e >> (msb - LOG_TABLE_BITS));
		else
			idx = LOG_TABLE_BITS'(e << (LOG_TABLE_BITS - msb));
		l2 = (64'(msb) << 16) + 64'(frac_log2(idx));
		prod = l2 * LN2_FIX;
		rounded = (prod + (64'd1 << (45 - FRAC_BITS))) >> (46 - FRAC_BITS);
		if (rounded > 64'(OUT_MAX))
			return OUT_MAX;
		return OUT_W'(rounded);
	endfunction

	// add one square to the running energy; on a frame end queue the frame's log
	task automatic absorb_sample(in_item_t it);
		int                  s;
		logic [ACC_BITS-1:0] sq;
		out_item_t           res;
		s = int'(it.sample);
		sq = ACC_BITS'(longint'(s) * longint'(s));
		if (energy_acc > ENERGY_FULL - sq) begin
			energy_acc = ENERGY_FULL;
			clip_seen = 1'b1;
		end else begin
			energy_acc = energy_acc + sq;
		end
		if (it.frame_end) begin
			if (energy_acc == '0) begin
				res.log_energy = '0;
				res.zero_energy = 1'b1;
			end else begin
				res.log_energy = ln_energy_q(energy_acc);
				res.zero_energy = 1'b0;
			end
			res.saturated = clip_seen;
			expected_logs.push_back(res);
			energy_acc = '0;
			clip_seen = 1'b0;
		end
	endtask

	task automatic push_beat(int s, bit last);
		in_item_t it;
		it.sample = SAMPLE_W'(s);
		it.frame_end = last;
		sample_backlog.push_back(it);
	endtask

	task automatic queue_frame(int len, mix_t kind);
		in_item_t it;
		for (int i = 0; i < len; i++) begin
			it.frame_end = (i == len - 1);
			case (kind)
				MIX_FULL:   it.sample = 16'($urandom);
				MIX_QUIET:  it.sample = 16'($urandom_range(8)) - 16'd4;
				MIX_SILENT: it.sample = '0;
				default: begin
					if ($urandom_range(1))
						it.sample = 16'h8000 | 16'($urandom_range(255));
					else
						it.sample = 16'h7fff ^ 16'($urandom_range(255));
				end
			endcase
			sample_backlog.push_back(it);
		end
	endtask

	task automatic queue_random_frames(int n_beats);
		int   queued;
		int   pick;
		int   len;
		mix_t kind;
		queued = 0;
		while (queued < n_beats) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				kind = MIX_FULL;
				len = $urandom_range(1, 8);
			end else if (pick < 65) begin
				kind = MIX_QUIET;
				len = $urandom_range(1, 4);
			end else if (pick < 75) begin
				kind = MIX_SILENT;
				len = $urandom_range(1, 3);
			end else if (pick < 88) begin
				kind = MIX_LOUD;
				len = $urandom_range(10, 40);
			end else begin
				kind = MIX_FULL;
				len = 1;
			end
			queue_frame(len, kind);
			queued += len;
		end
	endtask

	task automatic finish_phase();
		while (sample_backlog.size() != 0 || audio_ch.valid || expected_logs.size() != 0)
			@(posedge clk);
	endtask

	// input beats feed the prediction, output beats are checked against it
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (audio_ch.valid && audio_ch.ready) begin
				absorb_sample(audio_ch.data);
				beats_in++;
				beat_taken = 1'b1;
			end
			if (energy_ch.valid && energy_ch.ready) begin
				if (expected_logs.size() == 0) begin
					$error("unexpected energy beat: log_energy %0d zero_energy %0b saturated %0b",
						energy_ch.data.log_energy, energy_ch.data.zero_energy,
						energy_ch.data.saturated);
					err_count++;
				end else begin
					want = expected_logs.pop_front();
					frames_checked++;
					if (want.zero_energy)
						silent_frames++;
					if (want.saturated)
						clipped_frames++;
					if (energy_ch.data.log_energy !== want.log_energy) begin
						$error("log_energy mismatch: expected %0d, got %0d",
							want.log_energy, energy_ch.data.log_energy);
						err_count++;
					end
					if (energy_ch.data.zero_energy !== want.zero_energy) begin
						$error("zero_energy mismatch: expected %0b, got %0b",
							want.zero_energy, energy_ch.data.zero_energy);
						err_count++;
					end
					if (energy_ch.data.saturated !== want.saturated) begin
						$error("saturated mismatch: expected %0b, got %0b",
							want.saturated, energy_ch.data.saturated);
						err_count++;
					end
				end
			end
		end
	end

	// hold the beat until taken, then advance or idle
	always @(negedge clk) begin
		if (!arst_n) begin
			audio_ch.valid <= 1'b0;
		end else if (beat_taken || !audio_ch.valid) begin
			beat_taken = 1'b0;
			if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				audio_ch.data <= sample_backlog.pop_front();
				audio_ch.valid <= 1'b1;
			end else begin
				audio_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		energy_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);

	initial begin
		#20_000_000;
		$display("frame_log_energy_top verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		audio_ch.valid = 1'b0;
		audio_ch.data = '0;
		energy_ch.ready = 1'b0;
		energy_acc = '0;
		clip_seen = 1'b0;
		beat_taken = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		err_count = 0;
		beats_in = 0;
		frames_checked = 0;
		silent_frames = 0;
		clipped_frames = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// silence, unit energy, tiny energies below the table width, extremes
		push_beat(0, 1);
		push_beat(1, 1);
		push_beat(-1, 1);
		push_beat(2, 1);
		push_beat(3, 1);
		push_beat(5, 0);
		push_beat(-7, 1);
		push_beat(-32768, 1);
		push_beat(32767, 1);
		push_beat(0, 0);
		push_beat(0, 0);
		push_beat(0, 1);
		push_beat(-32768, 0);
		push_beat(32767, 0);
		push_beat(-32768, 0);
		push_beat(0, 0);
		push_beat(32767, 1);
		push_beat(100, 0);
		push_beat(-200, 0);
		push_beat(300, 1);
		push_beat(21845, 0);
		push_beat(-21846, 1);
		push_beat(1, 1);

		queue_random_frames(360);
		finish_phase();

		send_idle_pct = 80;
		recv_stall_pct = 0;
		queue_random_frames(360);
		finish_phase();

		send_idle_pct = 0;
		recv_stall_pct = 80;
		queue_random_frames(360);
		finish_phase();

		send_idle_pct = 9;
		recv_stall_pct = 9;
		queue_random_frames(360);
		finish_phase();

		repeat (30) @(posedge clk);
		if (expected_logs.size() != 0) begin
			$error("%0d frame results never arrived", expected_logs.size());
			err_count++;
		end
		$display("Run covered %0d sample beats and %0d checked frames over four idling phases,",
			beats_in, frames_checked);
		$display("including %0d silent frames and %0d clipped frames.",
			silent_frames, clipped_frames);
		if (err_count == 0)
			$display("frame_log_energy_top verification clean");
		else
			$display("frame_log_energy_top verification failed");
		$finish;
	end

endmodule
